// ===== rtl/core/fed_pkg.sv =====
// Shared types, widths and helpers for the frame euclidean distance unit.
package fed_pkg;

  localparam int PIX_W          = 8;
  localparam int SUM_W          = 38;
  localparam int DIST_W         = 27;
  localparam int SQD_W          = 18;          // four squared byte differences
  localparam int FRAC_W         = 8;           // fraction bits of the distance
  localparam int X_W            = SUM_W + 2 * FRAC_W;
  localparam int ROOT_STEPS     = X_W / 2;     // one result bit per step
  localparam int REM_W          = DIST_W + 2;
  localparam int CNT_W          = $clog2(ROOT_STEPS);
  localparam int MAX_PIXELS_DEF = 1048576;
  localparam longint SQ_PIXEL_MAX = 64'd260100; // 4 * 255 * 255

  // Controller to datapath
  typedef struct packed {
    logic adv;        // input stage moves on
    logic acc_en;     // accumulator takes the staged pixel
    logic root_load;  // frame total goes to the square root unit
    logic root_step;  // one step of the square root
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last1;      // staged pixel closes the frame
  } sts_t;

  // Squared absolute difference of two bytes
  function automatic logic [2*PIX_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

// ===== rtl/core/fed_in_if.sv =====
// Pixel pair channel: valid, ready and one pixel pair per beat.
interface fed_in_if;
  logic                     valid;
  logic                     ready;
  logic [fed_pkg::PIX_W-1:0] a_red;
  logic [fed_pkg::PIX_W-1:0] a_green;
  logic [fed_pkg::PIX_W-1:0] a_blue;
  logic [fed_pkg::PIX_W-1:0] a_alpha;
  logic [fed_pkg::PIX_W-1:0] b_red;
  logic [fed_pkg::PIX_W-1:0] b_green;
  logic [fed_pkg::PIX_W-1:0] b_blue;
  logic [fed_pkg::PIX_W-1:0] b_alpha;
  logic                     last_pixel;

  modport source (output valid, a_red, a_green, a_blue, a_alpha,
                  b_red, b_green, b_blue, b_alpha, last_pixel, input ready);
  modport sink   (input valid, a_red, a_green, a_blue, a_alpha,
                  b_red, b_green, b_blue, b_alpha, last_pixel, output ready);
endinterface

// ===== rtl/core/fed_out_if.sv =====
// Result channel: valid, ready and one frame result per beat.
interface fed_out_if;
  logic                      valid;
  logic                      ready;
  logic [fed_pkg::SUM_W-1:0]  sum_squares;
  logic [fed_pkg::DIST_W-1:0] distance;

  modport source (output valid, sum_squares, distance, input ready);
  modport sink   (input valid, sum_squares, distance, output ready);
endinterface

// ===== rtl/core/fed_ctrl.sv =====
// Controller: input stage valid, square root sequencing and result valid.
module fed_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fed_pkg::sts_t sts_i,
  output fed_pkg::cmd_t cmd_o
);
  import fed_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(ROOT_STEPS - 1);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             v1_q, v1_d;
  logic             ready;

  // Stall only when a frame end waits for the busy root unit
  assign ready = !(v1_q && sts_i.last1 && (state_q != ST_IDLE));

  always_comb begin
    cmd_o.adv       = ready;
    cmd_o.acc_en    = ready && v1_q;
    cmd_o.root_load = ready && v1_q && sts_i.last1;
    cmd_o.root_step = (state_q == ST_ROOT);
  end

  assign v1_d        = ready ? in_valid_i : v1_q;
  assign in_ready_o  = ready;
  assign out_valid_o = (state_q == ST_DONE);

  // Square root sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.root_load) begin
          state_d = ST_ROOT;
          cnt_d   = '0;
        end
      end
      ST_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= v1_d;
    end
  end

  // A frame reaches the root unit only while it is free
  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.root_load |-> state_q == ST_IDLE)
    else $error("root load while root unit busy");

  a_load_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.root_load |=> state_q == ST_ROOT && cnt_q == '0)
    else $error("root unit did not start after load");

  a_root_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT && cnt_q == CntLast |=> state_q == ST_DONE)
    else $error("root unit ran past its step count");

  a_result_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped before it was taken");

endmodule

// ===== rtl/core/fed_dpath.sv =====
// Datapath: squared differences, saturating accumulator, digit square root.
module fed_dpath #(
  parameter int unsigned MaxPixels = fed_pkg::MAX_PIXELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fed_pkg::cmd_t              cmd_i,
  output fed_pkg::sts_t              sts_o,
  input  logic [fed_pkg::PIX_W-1:0]  a_red_i,
  input  logic [fed_pkg::PIX_W-1:0]  a_green_i,
  input  logic [fed_pkg::PIX_W-1:0]  a_blue_i,
  input  logic [fed_pkg::PIX_W-1:0]  a_alpha_i,
  input  logic [fed_pkg::PIX_W-1:0]  b_red_i,
  input  logic [fed_pkg::PIX_W-1:0]  b_green_i,
  input  logic [fed_pkg::PIX_W-1:0]  b_blue_i,
  input  logic [fed_pkg::PIX_W-1:0]  b_alpha_i,
  input  logic                       last_pixel_i,
  output logic [fed_pkg::SUM_W-1:0]  sum_squares_o,
  output logic [fed_pkg::DIST_W-1:0] distance_o
);
  import fed_pkg::*;

  localparam logic [SUM_W-1:0] SumMax = SUM_W'(64'(MaxPixels) * SQ_PIXEL_MAX);

  logic [SQD_W-1:0]  add1_q, add1_d;
  logic              last1_q;
  logic [SUM_W-1:0]  acc_q;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  sum_q;
  logic [X_W-1:0]    xs_q;
  logic [REM_W-1:0]  rem_q;
  logic [DIST_W-1:0] root_q;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              take;

  // Input stage: four squared differences of the pixel pair
  assign add1_d = SQD_W'(sq_diff(a_red_i, b_red_i))
                + SQD_W'(sq_diff(a_green_i, b_green_i))
                + SQD_W'(sq_diff(a_blue_i, b_blue_i))
                + SQD_W'(sq_diff(a_alpha_i, b_alpha_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      add1_q  <= add1_d;
      last1_q <= last_pixel_i;
    end
  end

  assign sts_o.last1 = last1_q;

  // Saturating accumulate; the running total never exceeds SumMax
  assign sum_wide = {1'b0, acc_q} + (SUM_W + 1)'(add1_q);
  assign sum_new  = (sum_wide >= {1'b0, SumMax}) ? SumMax : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= last1_q ? '0 : sum_new;
    end
  end

  // Square root, two radicand bits per step
  assign rem_sh = {rem_q, xs_q[X_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      sum_q  <= sum_new;
      xs_q   <= {sum_new, {(2 * FRAC_W){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      xs_q   <= {xs_q[X_W-3:0], 2'b00};
      rem_q  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root_q <= {root_q[DIST_W-2:0], take};
    end
  end

  assign sum_squares_o = sum_q;
  assign distance_o    = root_q;

  // The total stays within the saturation bound
  a_acc_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= SumMax)
    else $error("accumulator above saturation bound");

  a_root_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root_step |=> {1'b0, rem_q} <= {root_q, 1'b0})
    else $error("root remainder out of range");

  a_frame_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root_load |=> acc_q == '0)
    else $error("accumulator not cleared at frame end");

endmodule

// ===== rtl/core/frame_euclidean_distance_unit.sv =====
// Top level of the frame euclidean distance unit.
//
//   channel | dir | beat content                                | ends frame
//   in_i    | in  | a/b red, green, blue, alpha bytes, last_pixel | last_pixel
//   out_o   | out | sum_squares (38 b), distance (27 b, 8 frac)   | one per frame
//
// One pixel pair is taken per cycle through a one-deep input stage while not stalled.
// A frame end hands the saturated total to a digit-serial square root;
// the next frame accumulates meanwhile.
// A further frame end stalls the input until the previous result is taken.
// rst_ni clears the total, the stage valid and the sequencer; no clearing pass.
module frame_euclidean_distance_unit #(
  parameter int unsigned MaxPixels = fed_pkg::MAX_PIXELS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  fed_in_if.sink    in_i,
  fed_out_if.source out_o
);
  import fed_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fed_dpath #(
    .MaxPixels (MaxPixels)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .a_red_i       (in_i.a_red),
    .a_green_i     (in_i.a_green),
    .a_blue_i      (in_i.a_blue),
    .a_alpha_i     (in_i.a_alpha),
    .b_red_i       (in_i.b_red),
    .b_green_i     (in_i.b_green),
    .b_blue_i      (in_i.b_blue),
    .b_alpha_i     (in_i.b_alpha),
    .last_pixel_i  (in_i.last_pixel),
    .sum_squares_o (out_o.sum_squares),
    .distance_o    (out_o.distance)
  );

endmodule
